// ----- design/addr_split_pkg.sv -----
// shared types, codes and constants for the address splitter
package addr_split_pkg;

    // default bound on the string length
    localparam int MAX_LEN_DEFAULT = 4096;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OFFS_W   = 12;
    localparam int SLEN_W   = 13;

    // separator characters
    localparam logic [BYTE_W-1:0] CHAR_AT    = 8'h40;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

    // parser phase codes
    localparam logic [1:0] PH_NODE     = 2'd0;
    localparam logic [1:0] PH_SERVER   = 2'd1;
    localparam logic [1:0] PH_RESOURCE = 2'd2;

    // incoming word: one byte of the string
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } addr_split_in_t;

    // outgoing word: the split of one string
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFS_W-1:0]   node_len;
        logic [OFFS_W-1:0]   server_start;
        logic [SLEN_W-1:0]   server_len;
        logic [OFFS_W-1:0]   resource_start;
        logic [OFFS_W-1:0]   resource_len;
    } addr_split_out_t;

endpackage

// ----- design/address_splitter.sv -----
// address splitter top level: byte-serial parse of node@server/resource
// the result word is registered when the last byte is taken and is valid in the cycle after
// throughput: one byte per cycle; the parse state is updated in the cycle a byte is taken
// the byte side stalls only while a finished result is held and the result side stalls
// reset (rst_n low, asynchronous) returns the parser to the node phase at offset zero
// and clears the result valid flag; the result word register itself has no reset
module address_splitter #(
    parameter int MAX_LEN = addr_split_pkg::MAX_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  addr_split_pkg::addr_split_in_t  src_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output addr_split_pkg::addr_split_out_t res_word
);
    import addr_split_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // parse state
    logic [1:0]          phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    sb_reg, sb_next;
    logic [POS_W-1:0]    rb_reg, rb_next;
    logic [STATUS_W-1:0] fault_reg, fault_next;

    // result register
    logic            res_valid_reg, res_valid_next;
    addr_split_out_t res_word_reg, res_word_next;

    // working values after this byte
    logic [1:0]          w_phase;
    logic [POS_W-1:0]    w_pos, w_sb, w_rb;
    logic [STATUS_W-1:0] w_fault;
    logic                is_at, is_slash, fin;
    logic                src_take, res_take;

    // handshakes
    assign src_stall = res_valid_reg & res_stall;
    assign src_take  = src_valid & ~src_stall;
    assign res_take  = res_valid_reg & ~res_stall;

    assign is_at    = (src_word.data_byte == CHAR_AT);
    assign is_slash = (src_word.data_byte == CHAR_SLASH);
    assign fin      = src_word.last;

    // per-byte parse
    always_comb
    begin
        w_phase = phase_reg;
        w_pos   = pos_reg;
        w_sb    = sb_reg;
        w_rb    = rb_reg;
        w_fault = fault_reg;
        if (pos_reg == MAX_POS)
        begin
            w_fault = ST_TOO_LONG;
        end
        else
        begin
            w_pos = pos_reg + POS_ONE;
            if (fault_reg == ST_OK)
            begin
                case (phase_reg)
                    PH_NODE:
                    begin
                        if (is_at)
                        begin
                            if (pos_reg == '0 || fin)
                            begin
                                w_fault = ST_MALFORMED;
                            end
                            else
                            begin
                                w_sb    = pos_reg + POS_ONE;
                                w_phase = PH_SERVER;
                            end
                        end
                        else if (is_slash)
                        begin
                            // prefix is the server, starting at offset zero
                            if (pos_reg == '0 || fin)
                            begin
                                w_fault = ST_MALFORMED;
                                w_phase = PH_SERVER;
                            end
                            else
                            begin
                                w_rb    = pos_reg + POS_ONE;
                                w_phase = PH_RESOURCE;
                            end
                        end
                    end
                    PH_SERVER:
                    begin
                        if (is_at)
                        begin
                            w_fault = ST_MALFORMED;
                        end
                        else if (is_slash)
                        begin
                            if (pos_reg == '0 || fin || pos_reg == sb_reg)
                            begin
                                w_fault = ST_MALFORMED;
                            end
                            else
                            begin
                                w_rb    = pos_reg + POS_ONE;
                                w_phase = PH_RESOURCE;
                            end
                        end
                    end
                    default:
                    begin
                        // resource part takes any byte
                    end
                endcase
            end
        end
    end

    // result fields from the working values
    always_comb
    begin
        res_word_next        = '0;
        res_word_next.status = w_fault;
        if (w_fault == ST_OK)
        begin
            if (w_sb != '0)
            begin
                res_word_next.node_len = OFFS_W'(w_sb - POS_ONE);
            end
            case (w_phase)
                PH_NODE:
                begin
                    res_word_next.server_len = SLEN_W'(w_pos);
                end
                PH_SERVER:
                begin
                    res_word_next.server_start = OFFS_W'(w_sb);
                    res_word_next.server_len   = SLEN_W'(w_pos - w_sb);
                end
                default:
                begin
                    res_word_next.server_start   = OFFS_W'(w_sb);
                    res_word_next.server_len     = SLEN_W'(w_rb - POS_ONE - w_sb);
                    res_word_next.resource_start = OFFS_W'(w_rb);
                    res_word_next.resource_len   = OFFS_W'(w_pos - w_rb);
                end
            endcase
        end
    end

    // next state: parse state back to reset values after the last byte, result marked valid
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        sb_next        = sb_reg;
        rb_next        = rb_reg;
        fault_next     = fault_reg;
        res_valid_next = res_valid_reg;
        if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        if (src_take)
        begin
            if (fin)
            begin
                phase_next     = PH_NODE;
                pos_next       = '0;
                sb_next        = '0;
                rb_next        = '0;
                fault_next     = ST_OK;
                res_valid_next = 1'b1;
            end
            else
            begin
                phase_next = w_phase;
                pos_next   = w_pos;
                sb_next    = w_sb;
                rb_next    = w_rb;
                fault_next = w_fault;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NODE;
            pos_reg       <= '0;
            sb_reg        <= '0;
            rb_reg        <= '0;
            fault_reg     <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            sb_reg        <= sb_next;
            rb_reg        <= rb_next;
            fault_reg     <= fault_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (src_take && fin)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // checks
    a_fault_zeroes_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.status != ST_OK |->
            res_word.node_len == '0 && res_word.server_start == '0 &&
            res_word.server_len == '0 && res_word.resource_start == '0 &&
            res_word.resource_len == '0)
        else $error("faulted result carries non-zero fields");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("byte count beyond the length bound");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        src_take && fin |=>
            pos_reg == '0 && phase_reg == PH_NODE && fault_reg == ST_OK && res_valid_reg)
        else $error("parser not cleared after last byte");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.status <= ST_TOO_LONG)
        else $error("unused status code");

endmodule

// ----- sim/tb_address_splitter.sv -----
// self-checking bench for the address splitter: directed and random strings against a predictor
module tb_address_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import addr_split_pkg::*;

    localparam int RANDOM_BYTES   = 1150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [BYTE_W-1:0] text_t[$];

    // predicts the split of each string and checks the result words in order
    class split_scoreboard;
        int unsigned         max_len;
        logic [1:0]          phase;
        logic [SLEN_W-1:0]   position;
        logic [OFFS_W-1:0]   server_begin;
        logic [OFFS_W-1:0]   resource_begin;
        logic [STATUS_W-1:0] fault;
        addr_split_out_t     pending_splits[$];
        int unsigned         failures;
        int unsigned         bytes_taken;
        int unsigned         status_seen[3];

        function new(int unsigned limit);
            max_len = limit;
            failures = 0;
            bytes_taken = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_NODE;
            position = '0;
            server_begin = '0;
            resource_begin = '0;
            fault = ST_OK;
        endfunction

        // accepted byte word: advance the parse, queue a split on the last byte
        function void note_byte(addr_split_in_t w);
            addr_split_out_t split;
            bytes_taken++;
            if (position >= SLEN_W'(max_len)) begin
                fault = ST_TOO_LONG;
            end
            else begin
                if (fault == ST_OK) begin
                    if (phase == PH_NODE && w.data_byte == CHAR_AT) begin
                        // empty node, or '@' as the final byte
                        if (position == '0 || w.last) begin
                            fault = ST_MALFORMED;
                        end
                        else begin
                            server_begin = OFFS_W'(position + 1'b1);
                            phase = PH_SERVER;
                        end
                    end
                    else if (phase == PH_SERVER && w.data_byte == CHAR_AT) begin
                        // second '@' inside the server
                        fault = ST_MALFORMED;
                    end
                    else if (phase != PH_RESOURCE && w.data_byte == CHAR_SLASH) begin
                        // a slash in the node phase makes the prefix the server
                        if (position == '0 || w.last || position == SLEN_W'(server_begin)) begin
                            fault = ST_MALFORMED;
                        end
                        else begin
                            resource_begin = OFFS_W'(position + 1'b1);
                            phase = PH_RESOURCE;
                        end
                    end
                end
                position = position + 1'b1;
            end
            if (!w.last) return;

            split = '0;
            split.status = fault;
            if (fault == ST_OK) begin
                if (server_begin != '0) split.node_len = server_begin - 1'b1;
                if (phase == PH_NODE) begin
                    split.server_len = position;
                end
                else if (phase == PH_SERVER) begin
                    split.server_start = server_begin;
                    split.server_len = position - SLEN_W'(server_begin);
                end
                else begin
                    split.server_start = server_begin;
                    split.server_len = SLEN_W'(resource_begin - 1'b1 - server_begin);
                    split.resource_start = resource_begin;
                    split.resource_len = OFFS_W'(position - SLEN_W'(resource_begin));
                end
            end
            pending_splits.push_back(split);
            restart();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // accepted result word: compare with the oldest predicted split
        function void check_split(addr_split_out_t got);
            addr_split_out_t want;
            if (pending_splits.size() == 0) begin
                failures++;
                $display("%0t: result word expected none, got status %0d node_len %0d",
                         $time, got.status, got.node_len);
                return;
            end
            want = pending_splits.pop_front();
            if (got.status <= ST_TOO_LONG) status_seen[got.status]++;
            compare_field("status", want.status, got.status);
            compare_field("node_len", want.node_len, got.node_len);
            compare_field("server_start", want.server_start, got.server_start);
            compare_field("server_len", want.server_len, got.server_len);
            compare_field("resource_start", want.resource_start, got.resource_start);
            compare_field("resource_len", want.resource_len, got.resource_len);
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            src_valid;
    logic            src_stall;
    addr_split_in_t  src_word;
    logic            res_valid;
    logic            res_stall;
    addr_split_out_t res_word;

    split_scoreboard sb;
    bit              steady = 1'b0;
    bit              hold_req = 1'b0;
    int unsigned     idle_cycles = 0;

    address_splitter #(
        .MAX_LEN(MAX_LEN_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_word(src_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // any byte other than a separator
    function automatic logic [BYTE_W-1:0] name_char();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255)); while (c == CHAR_AT || c == CHAR_SLASH);
        return c;
    endfunction

    // node, optional '@', server, optional '/', then resource bytes of any value
    function automatic text_t compose(int node_n, bit at, int server_n, bit slash, int res_n);
        text_t t;
        repeat (node_n) t.push_back(name_char());
        if (at) t.push_back(CHAR_AT);
        repeat (server_n) t.push_back(name_char());
        if (slash) t.push_back(CHAR_SLASH);
        repeat (res_n) t.push_back(BYTE_W'($urandom_range(0, 255)));
        return t;
    endfunction

    function automatic text_t from_str(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    // offer one byte word, with an occasional idle cycle in front, and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        addr_split_in_t w;
        w.data_byte = b;
        w.last = fin;
        if (!steady && $urandom_range(0, 99) < 12) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word <= w;
        do @(posedge clk); while (!(src_valid && !src_stall));
        sb.note_byte(w);
    endtask

    task automatic send_string(input text_t s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                res_stall <= !steady && ($urandom_range(0, 99) < 12);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall) sb.check_split(res_word);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (res_valid && !res_stall)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        text_t       t;
        int unsigned strings_sent;
        int unsigned random_bytes;
        int          node_n;
        bit          at;
        bit          slash;

        sb = new(MAX_LEN_DEFAULT);
        rst_n <= 1'b0;
        src_valid <= 1'b0;
        src_word <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // separator corner cases and byte extremes
        send_string(from_str("@"));
        send_string(from_str("@x/"));
        send_string(from_str("a@"));
        send_string(from_str("a/"));
        send_string(from_str("/a"));
        send_string(from_str("a@/b"));
        send_string(from_str("a@b@c"));
        send_string(from_str("s/r"));
        send_string(from_str("a@b/@/"));
        t = {8'h00, CHAR_AT, 8'hFF};
        send_string(t);

        // random strings, mostly well formed
        strings_sent = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            steady = (strings_sent >= 100 && strings_sent < 140);
            if (strings_sent == 20) hold_req = 1'b1;
            if (strings_sent == 60) begin
                // let the result side drain completely
                src_valid <= 1'b0;
                while (sb.pending_splits.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 99) < 80) begin
                node_n = $urandom_range(1, 6);
                at = ($urandom_range(0, 3) != 0);
                slash = $urandom_range(0, 1);
                t = compose(node_n, at, at ? $urandom_range(1, 6) : 0,
                            slash, slash ? $urandom_range(1, 6) : 0);
            end
            else begin
                t.delete();
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 2) == 0)
                        t.push_back($urandom_range(0, 1) ? CHAR_AT : CHAR_SLASH);
                    else
                        t.push_back(BYTE_W'($urandom_range(0, 255)));
                end
            end
            send_string(t);
            random_bytes += t.size();
            strings_sent++;
        end
        steady = 1'b0;

        // drain, then wait for any stray result
        src_valid <= 1'b0;
        while (sb.pending_splits.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d bytes in, splits checked: %0d ok, %0d malformed, %0d too long",
                 sb.bytes_taken, sb.status_seen[ST_OK], sb.status_seen[ST_MALFORMED],
                 sb.status_seen[ST_TOO_LONG]);
        $display("covered separator faults, random strings with byte extremes, long holds");
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
